// ===== hdl/boxds_pkg.sv =====
// Shared constants, reciprocal table and queue entry type for the box downscaler.
`timescale 1ns / 1ps

package boxds_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_FACTOR  = 16;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 16;
    localparam int SUMS_W      = 3 * SUM_W;
    localparam int FACTOR_W    = 5;
    localparam int SIZE_W      = 13;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int SQ_W        = $clog2(MAX_FACTOR);

    // queue depth must stay a power of two (pointers wrap naturally)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = SIZE_W;

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd2;
    localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 13'd480;

    // quotient = (sum * RECIP[f]) >> RECIP_SHIFT, RECIP[f] = ceil(2^24 / f^2);
    // exact for every 16-bit sum
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 25;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP [0:MAX_FACTOR] = '{
        25'd16777216, 25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
        25'd671089,   25'd466034,   25'd342393,  25'd262144,  25'd207127,
        25'd167773,   25'd138655,   25'd116509,  25'd99274,   25'd85599,
        25'd74566,    25'd65536
    };

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [COL_W-1:0] col;      // output column, sum store address
        logic             first;    // top-left pixel of the square
        logic             last;     // bottom-right pixel, gives a result
        logic             eor;
        logic             eof;
    } t_item;

endpackage

// ===== hdl/boxds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module boxds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/boxds_queue.sv =====
// Small show-ahead queue of classified pixels between front and back.
`timescale 1ns / 1ps

module boxds_queue
    import boxds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_full,
    output logic  o_empty
);

    t_item              r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== hdl/boxds_front.sv =====
// Front end: configuration, frame position counters and pixel classification.
`timescale 1ns / 1ps

module boxds_front
    import boxds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_blue_in,
    output logic                  o_in_stall,
    input  logic                  i_full,
    output logic                  o_push,
    output t_item                 o_item,
    output logic [FACTOR_W-1:0]   o_factor
);

    logic [FACTOR_W-1:0] r_factor;
    logic [SIZE_W-1:0]   r_width;
    logic [SIZE_W-1:0]   r_height;

    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [SQ_W-1:0]     r_cis;
    logic [SQ_W-1:0]     r_ris;
    logic [COL_W-1:0]    r_oc;
    logic                r_col_ok;
    logic                r_col_last;
    logic                r_row_ok;
    logic                r_row_last;

    logic [FACTOR_W-1:0] f_eff;
    logic [SIZE_W-1:0]   w_eff;
    logic [SIZE_W-1:0]   h_eff;
    logic [SIZE_W-1:0]   f_ext;
    logic [SIZE_W-1:0]   f2_ext;
    logic [SIZE_W-1:0]   col_ext;
    logic [SIZE_W-1:0]   row_ext;
    logic                col_ok;
    logic                col_last;
    logic                row_ok;
    logic                row_last;
    logic                cis_wrap;
    logic                ris_wrap;
    logic                col_end;
    logic                row_end;
    logic                accept;

    // clamp the registers to their usable ranges
    always_comb begin
        if (r_factor == '0) begin
            f_eff = FACTOR_W'(1);
        end else if (r_factor > FACTOR_W'(MAX_FACTOR)) begin
            f_eff = FACTOR_W'(MAX_FACTOR);
        end else begin
            f_eff = r_factor;
        end
        if (r_width == '0) begin
            w_eff = SIZE_W'(1);
        end else if (r_width > SIZE_W'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = SIZE_W'(1);
        end else if (r_height > SIZE_W'(MAX_HEIGHT)) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // square flags are decided at the square's first column / row and held
    always_comb begin
        f_ext    = SIZE_W'(f_eff);
        f2_ext   = SIZE_W'({f_eff, 1'b0});
        col_ext  = SIZE_W'(r_col);
        row_ext  = SIZE_W'(r_row);
        col_ok   = (r_cis == '0) ? ((col_ext + f_ext) <= w_eff) : r_col_ok;
        col_last = (r_cis == '0) ? ((col_ext + f2_ext) > w_eff) : r_col_last;
        row_ok   = (r_ris == '0) ? ((row_ext + f_ext) <= h_eff) : r_row_ok;
        row_last = (r_ris == '0) ? ((row_ext + f2_ext) > h_eff) : r_row_last;
        cis_wrap = ((FACTOR_W'(r_cis) + FACTOR_W'(1)) == f_eff);
        ris_wrap = ((FACTOR_W'(r_ris) + FACTOR_W'(1)) == f_eff);
        col_end  = ((col_ext + SIZE_W'(1)) >= w_eff);
        row_end  = ((row_ext + SIZE_W'(1)) >= h_eff);
        accept   = i_in_valid && !i_full;
    end

    always_comb begin
        o_item.red   = i_red_in;
        o_item.green = i_green_in;
        o_item.blue  = i_blue_in;
        o_item.col   = r_oc;
        o_item.first = (r_cis == '0) && (r_ris == '0);
        o_item.last  = cis_wrap && ris_wrap;
        o_item.eor   = col_last;
        o_item.eof   = col_last && row_last;
    end

    assign o_push     = accept && col_ok && row_ok;
    assign o_in_stall = i_full;
    assign o_factor   = f_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor   <= FACTOR_RESET;
            r_width    <= WIDTH_RESET;
            r_height   <= HEIGHT_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_cis      <= '0;
            r_ris      <= '0;
            r_oc       <= '0;
            r_col_ok   <= 1'b0;
            r_col_last <= 1'b0;
            r_row_ok   <= 1'b0;
            r_row_last <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_FACTOR: r_factor <= i_cfg_data[FACTOR_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
            // any known register restarts the frame
            if (i_cfg_index inside {REG_FACTOR, REG_WIDTH, REG_HEIGHT}) begin
                r_col <= '0;
                r_row <= '0;
                r_cis <= '0;
                r_ris <= '0;
                r_oc  <= '0;
            end
        end else if (accept) begin
            r_col_ok   <= col_ok;
            r_col_last <= col_last;
            r_row_ok   <= row_ok;
            r_row_last <= row_last;
            if (col_end) begin
                r_col <= '0;
                r_cis <= '0;
                r_oc  <= '0;
                if (row_end) begin
                    r_row <= '0;
                    r_ris <= '0;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                    r_ris <= ris_wrap ? '0 : r_ris + SQ_W'(1);
                end
            end else begin
                r_col <= r_col + COL_W'(1);
                r_cis <= cis_wrap ? '0 : r_cis + SQ_W'(1);
                if (cis_wrap) begin
                    r_oc <= r_oc + COL_W'(1);
                end
            end
        end
    end

endmodule

// ===== hdl/boxds_back.sv =====
// Back end: column sum read-modify-write, mean by reciprocal multiply, output register.
`timescale 1ns / 1ps

module boxds_back
    import boxds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_head,
    input  logic                i_empty,
    output logic                o_pop,
    input  logic [FACTOR_W-1:0] i_factor,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [PIX_W-1:0]    o_red_out,
    output logic [PIX_W-1:0]    o_green_out,
    output logic [PIX_W-1:0]    o_blue_out,
    output logic                o_end_of_row,
    output logic                o_end_of_frame
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV
    } t_state;

    t_state              r_state;
    t_item               r_item;
    logic [SUM_W-1:0]    r_sum_r;
    logic [SUM_W-1:0]    r_sum_g;
    logic [SUM_W-1:0]    r_sum_b;
    logic                r_out_valid;
    logic [PIX_W-1:0]    r_red;
    logic [PIX_W-1:0]    r_green;
    logic [PIX_W-1:0]    r_blue;
    logic                r_eor;
    logic                r_eof;

    logic [SUMS_W-1:0]   ram_rdata;
    logic                ram_we;
    logic [SUMS_W-1:0]   ram_wdata;
    logic [SUM_W-1:0]    sum_r;
    logic [SUM_W-1:0]    sum_g;
    logic [SUM_W-1:0]    sum_b;
    logic [RECIP_W-1:0]  recip;
    logic [PROD_W-1:0]   prod_r;
    logic [PROD_W-1:0]   prod_g;
    logic [PROD_W-1:0]   prod_b;
    logic                out_free;

    boxds_ram #(
        .WIDTH (SUMS_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_item.col),
        .i_wdata (ram_wdata),
        .i_raddr (i_head.col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_pop = (r_state == S_IDLE) && !i_empty;
        // first pixel of a square starts the sum afresh
        if (r_item.first) begin
            sum_r = SUM_W'(r_item.red);
            sum_g = SUM_W'(r_item.green);
            sum_b = SUM_W'(r_item.blue);
        end else begin
            sum_r = ram_rdata[SUM_W-1:0] + SUM_W'(r_item.red);
            sum_g = ram_rdata[2*SUM_W-1:SUM_W] + SUM_W'(r_item.green);
            sum_b = ram_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(r_item.blue);
        end
        ram_we    = (r_state == S_ACC);
        ram_wdata = {sum_b, sum_g, sum_r};
        recip     = RECIP[i_factor];
        prod_r    = PROD_W'(r_sum_r) * PROD_W'(recip);
        prod_g    = PROD_W'(r_sum_g) * PROD_W'(recip);
        prod_b    = PROD_W'(r_sum_b) * PROD_W'(recip);
        out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DIV a leaving result is replaced by the new one below
            if (r_out_valid && !i_out_stall && r_state != S_DIV) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_item  <= i_head;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum_r <= sum_r;
                    r_sum_g <= sum_g;
                    r_sum_b <= sum_b;
                    r_state <= r_item.last ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    if (out_free) begin
                        r_red       <= prod_r[RECIP_SHIFT +: PIX_W];
                        r_green     <= prod_g[RECIP_SHIFT +: PIX_W];
                        r_blue      <= prod_b[RECIP_SHIFT +: PIX_W];
                        r_eor       <= r_item.eor;
                        r_eof       <= r_item.eof;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red_out      = r_red;
    assign o_green_out    = r_green;
    assign o_blue_out     = r_blue;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

endmodule

// ===== hdl/box_average_downscale_top.sv =====
// Top level of the streaming box-average image downscaler.
`timescale 1ns / 1ps

// Box-average downscaler. RGB pixels come in raster order, one request per
// pixel; every block_factor x block_factor square gives one request out, the
// per-channel truncated mean, issued with the square's bottom-right pixel.
// end_of_row / end_of_frame flag the last pixel of an output row / frame.
// Columns and rows past the last whole square are swallowed. Writing any
// register (only while idle) restarts the frame at its top-left corner.
// Rate: the front takes one pixel per clock while its 4-entry queue has room.
// Pixels outside any whole square never enter the queue. A kept pixel is
// popped in S_IDLE, which reads its column sum, and written back in S_ACC -
// a read then a write of the column sum memory, one port each - and the pixel
// closing a square then passes S_DIV, the reciprocal multiply that forms the
// mean, which waits while the output is stalled. The back end pops the next
// pixel only once it is back in S_IDLE. No clearing pass after reset: the
// first pixel of each square overwrites its column sum.
module box_average_downscale_top
    import boxds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_blue_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_red_out,
    output logic [PIX_W-1:0]      o_green_out,
    output logic [PIX_W-1:0]      o_blue_out,
    output logic                  o_end_of_row,
    output logic                  o_end_of_frame
);

    t_item               q_in;
    t_item               q_head;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [FACTOR_W-1:0] factor;

    // front: config, position counters, square classification
    boxds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_in_stall  (o_in_stall),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_item      (q_in),
        .o_factor    (factor)
    );

    // decouples pixel intake from the sum memory's read-modify-write
    boxds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: accumulate per output column, divide by area, hold result
    boxds_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .i_factor       (factor),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

    // queue never overrun or underrun
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("pixel pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pixel popped from empty queue");

    // frame end is always also a row end
    a_eof_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_end_of_row || !o_end_of_frame))
        else $error("end of frame without end of row");

    // a full queue means the intake is held off
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> o_in_stall)
        else $error("intake open while queue full");

endmodule

// ===== test/tb_box_average_downscale_top.sv =====
// Self-checking testbench for the box-average image downscaler.
`timescale 1ns / 1ps

// Pixel requests are queued by the stimulus process and presented by a
// clocked driver. The driver mirrors every accepted pixel into a local
// box-average model, which queues the averaged pixel it should produce.
// A clocked monitor takes result requests and checks them in order against
// that queue. Registers change only when the block has drained. The opening
// phases are hand-picked frames. Random frames follow, with bursts of
// idling on both sides. The run ends at full rate with the largest square
// and a short stretch of an oversize frame.
module tb_box_average_downscale_top;
    import boxds_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int SETTLE_CYCLES = 32;          // 4-deep queue
    localparam int RANDOM_PIXELS = 110;
    localparam longint TIMEOUT_NS = 64'd2_000_000;

    // Index 3 decodes to no register: a write there must not restart the frame.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum {FILL_RANDOM, FILL_WHITE, FILL_BLACK} t_fill;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_col_sum;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             eor;
        logic             eof;
    } t_mean;

    // DUT connections; every input has a known value from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_FACTOR;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic [PIX_W-1:0]      red_drv     = '0;
    logic [PIX_W-1:0]      green_drv   = '0;
    logic [PIX_W-1:0]      blue_drv    = '0;
    logic                  out_stall   = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [PIX_W-1:0]      o_red_out;
    logic [PIX_W-1:0]      o_green_out;
    logic [PIX_W-1:0]      o_blue_out;
    logic                  o_end_of_row;
    logic                  o_end_of_frame;

    // Local model of the block: registers, frame position and column sums
    logic [FACTOR_W-1:0] model_factor = FACTOR_RESET;
    logic [SIZE_W-1:0]   model_width  = WIDTH_RESET;
    logic [SIZE_W-1:0]   model_height = HEIGHT_RESET;
    t_col_sum            column_totals [MAX_WIDTH];
    int unsigned         col_pos, row_pos, col_in_sq, row_in_sq;

    t_pixel pixel_queue [$];                    // pixels waiting to be requested
    t_mean  pending_means [$];                  // averages not yet returned

    bit idle_on = 1'b1;                         // random gaps and stalls allowed
    int gap_left, stall_left;
    int pixels_sent, means_checked, mismatches, settings_used;

    box_average_downscale_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_red_in       (red_drv),
        .i_green_in     (green_drv),
        .i_blue_in      (blue_drv),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Factor 0 acts as 1 and anything past the largest square saturates.
    function automatic int unsigned eff_factor(input logic [FACTOR_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_FACTOR) return MAX_FACTOR;
        return v;
    endfunction

    // Zero sizes act as 1; oversize frames saturate.
    function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v,
                                               input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    // Mostly any level, now and then full black or full white.
    function automatic logic [PIX_W-1:0] pick_level();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom);
    endfunction

    // One accepted pixel through the box-average model. The sum of a column
    // restarts on the square's top-left pixel; the bottom-right pixel yields
    // the mean. Pixels outside whole squares only move the counters.
    task automatic box_mean_step(input t_pixel px);
        int unsigned f, w, h, out_w, out_h, oc, orow, area;
        t_col_sum s;
        t_mean m;
        f = eff_factor(model_factor);
        w = clamp_size(model_width, MAX_WIDTH);
        h = clamp_size(model_height, MAX_HEIGHT);
        out_w = w / f;
        out_h = h / f;
        oc = col_pos / f;
        orow = row_pos / f;
        if (oc < out_w && orow < out_h) begin
            s = (col_in_sq == 0 && row_in_sq == 0) ? '0 : column_totals[oc];
            s.red   = s.red + px.red;
            s.green = s.green + px.green;
            s.blue  = s.blue + px.blue;
            column_totals[oc] = s;
            if (col_in_sq == f - 1 && row_in_sq == f - 1) begin
                area = f * f;
                m.red   = PIX_W'(s.red / area);
                m.green = PIX_W'(s.green / area);
                m.blue  = PIX_W'(s.blue / area);
                m.eor   = (oc == out_w - 1);
                m.eof   = m.eor && (orow == out_h - 1);
                pending_means.push_back(m);
            end
        end
        col_in_sq = (col_in_sq + 1 == f) ? 0 : col_in_sq + 1;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            col_in_sq = 0;
            row_in_sq = (row_in_sq + 1 == f) ? 0 : row_in_sq + 1;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
                row_in_sq = 0;
            end
        end
        pixels_sent++;
    endtask

    // Driver: a pixel request is taken when valid is high and stall is low.
    // A new pixel (or a gap) is chosen only once the current one is gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall)
                box_mean_step('{red_drv, green_drv, blue_drv});
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (idle_on && pixel_queue.size() != 0
                             && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 7) - 1;
                    in_valid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    t_pixel p;
                    p = pixel_queue.pop_front();
                    in_valid  <= 1'b1;
                    red_drv   <= p.red;
                    green_drv <= p.green;
                    blue_drv  <= p.blue;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    // Monitor: checks each taken result request, then picks the next stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                t_mean want;
                if (pending_means.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, o_red_out, o_green_out, o_blue_out);
                end else begin
                    want = pending_means.pop_front();
                    if (o_red_out !== want.red)
                        report_field("red", want.red, o_red_out);
                    if (o_green_out !== want.green)
                        report_field("green", want.green, o_green_out);
                    if (o_blue_out !== want.blue)
                        report_field("blue", want.blue, o_blue_out);
                    if (o_end_of_row !== want.eor)
                        report_field("end_of_row", want.eor, o_end_of_row);
                    if (o_end_of_frame !== want.eof)
                        report_field("end_of_frame", want.eof, o_end_of_frame);
                    means_checked++;
                end
            end
            if (idle_on && stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Wait until every pixel is taken and every average returned, then give
    // pixels that produce nothing time to leave the pipeline.
    task automatic drain_and_settle();
        do @(posedge i_clk);
        while (pixel_queue.size() != 0 || in_valid || pending_means.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write on the plain write port; the model follows at once as
    // the block is idle. Real registers restart the frame, the spare does not.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FACTOR: model_factor = data[FACTOR_W-1:0];
            REG_WIDTH:  model_width  = data;
            REG_HEIGHT: model_height = data;
            default: ;
        endcase
        if (idx != REG_SPARE) begin
            col_pos = 0;
            row_pos = 0;
            col_in_sq = 0;
            row_in_sq = 0;
        end
        settings_used++;
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] factor_word,
                             input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] height);
        write_reg(REG_FACTOR, factor_word);
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
    endtask

    task automatic queue_pixels(input int n, input t_fill fill);
        t_pixel p;
        for (int k = 0; k < n; k++) begin
            case (fill)
                FILL_WHITE: p = '1;
                FILL_BLACK: p = '0;
                default:    p = '{pick_level(), pick_level(), pick_level()};
            endcase
            pixel_queue.push_back(p);
        end
        drain_and_settle();
    endtask

    initial begin
        int n, random_sent, frames;
        int unsigned f, w, h;
        logic [CFG_DATA_W-1:0] word;
        t_fill fill;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no shrink, 3x2 frame, channel extremes pass straight through
        set_frame(13'd1, 13'd3, 13'd2);
        pixel_queue.push_back('{8'd0,   8'd0,   8'd0});
        pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
        pixel_queue.push_back('{8'd1,   8'd128, 8'd254});
        pixel_queue.push_back('{8'd254, 8'd127, 8'd1});
        pixel_queue.push_back('{8'd170, 8'd85,  8'd15});
        pixel_queue.push_back('{8'd85,  8'd170, 8'd240});
        drain_and_settle();

        // Factor 2 on 3x2: last column dropped, means truncate
        write_reg(REG_FACTOR, 13'd2);
        pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
        pixel_queue.push_back('{8'd255, 8'd0,   8'd1});
        pixel_queue.push_back('{8'd7,   8'd7,   8'd7});
        pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
        pixel_queue.push_back('{8'd254, 8'd0,   8'd2});
        pixel_queue.push_back('{8'd9,   8'd9,   8'd9});
        drain_and_settle();

        // Zero factor, width and height all act as 1; high data bits ignored
        set_frame(13'h1FE0, 13'd0, 13'd0);
        pixel_queue.push_back('{8'd200, 8'd100, 8'd50});
        pixel_queue.push_back('{8'd3,   8'd2,   8'd1});
        drain_and_settle();

        // Factor wider than the frame: nothing ever comes out
        set_frame(13'd3, 13'd2, 13'd5);
        queue_pixels(4, FILL_WHITE);

        // A spare-index write mid-square must leave the frame position alone
        set_frame(13'h1FE2, 13'd2, 13'd2);
        pixel_queue.push_back('{8'd255, 8'd255, 8'd0});
        pixel_queue.push_back('{8'd255, 8'd254, 8'd1});
        drain_and_settle();
        write_reg(REG_SPARE, 13'h1FFF);
        pixel_queue.push_back('{8'd255, 8'd255, 8'd3});
        pixel_queue.push_back('{8'd254, 8'd255, 8'd0});
        drain_and_settle();

        // Random frames: small sizes, random register subsets, part frames
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0) begin
                word = CFG_DATA_W'($urandom);
                case ($urandom_range(0, 7))
                    0:       word[FACTOR_W-1:0] = '0;
                    1:       word[FACTOR_W-1:0] = FACTOR_W'($urandom_range(16, 31));
                    default: word[FACTOR_W-1:0] = FACTOR_W'($urandom_range(1, 4));
                endcase
                write_reg(REG_FACTOR, word);
            end
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(0, 12)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(0, 9)));
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            f = eff_factor(model_factor);
            w = clamp_size(model_width, MAX_WIDTH);
            h = clamp_size(model_height, MAX_HEIGHT);
            frames = $urandom_range(1, 3);
            n = w * h * frames + $urandom_range(0, w);
            if (n > 40) n = 40;
            case ($urandom_range(0, 15))
                0, 1:    fill = FILL_WHITE;
                2:       fill = FILL_BLACK;
                default: fill = FILL_RANDOM;
            endcase
            queue_pixels(n, fill);
            random_sent += n;
        end

        // Final stretch at full rate: saturated factor on a 16x16 white frame,
        // 16-bit sums at their peak, then a few pixels of an oversize frame
        idle_on = 1'b0;
        set_frame(13'h1FFF, 13'd16, 13'd16);
        queue_pixels(256, FILL_WHITE);
        set_frame(13'd1, 13'h1FFF, 13'h1FFF);
        queue_pixels(8, FILL_RANDOM);

        $display("Run covered %0d pixel requests over %0d register writes,",
                 pixels_sent, settings_used);
        $display("with %0d averaged pixels checked and %0d mismatches.",
                 means_checked, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d averages still outstanding", pending_means.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
